// ===== src/nps_pkg.sv =====
`default_nettype none

package nps_pkg;

    // Fixed field widths of the streams and the register
    localparam int IDX_WIDTH   = 4;
    localparam int ID_WIDTH    = 16;
    localparam int COUNT_WIDTH = 5;
    localparam int DIST_WIDTH  = 18;

    // Largest reported squared distance; larger values saturate here
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    // Defaults for the top-level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COORD_WIDTH_DEF = 8;

    // Command codes carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_entry;   // store the accepted write item in the table
        logic start;      // latch the query point and clear the running best
        logic step;       // read the next table entry
        logic load_out;   // move the running best into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;      // configured count is zero
        logic last;       // the entry being read is the last one searched
        logic busy;       // compare pipeline still holds entries
        logic out_free;   // output register can take a result this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/nps_ram.sv =====
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/nps_ctrl.sv =====
`default_nettype none

module nps_ctrl
    import nps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_command,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_xfer;

    // Items are taken only between queries
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Commands to the datapath
    always_comb begin
        cmd          = '0;
        cmd.wr_entry = in_xfer && (s_command == CMD_WRITE);
        cmd.start    = in_xfer && (s_command == CMD_QUERY);
        cmd.step     = (state_reg == S_RUN);
        cmd.load_out = (state_reg == S_FIN) && stat.out_free;
    end

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer && (s_command == CMD_QUERY)) begin
                    state_next = stat.empty ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                if (stat.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!stat.busy) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/nps_datapath.sv =====
`default_nettype none

module nps_datapath
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_WIDTH-1:0] cfg_wr_data,
    input  wire logic [IDX_WIDTH-1:0]   in_index,
    input  wire logic [ID_WIDTH-1:0]    in_id,
    input  wire logic [COORD_WIDTH-1:0] in_x,
    input  wire logic [COORD_WIDTH-1:0] in_y,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [ID_WIDTH-1:0]         out_id,
    output logic                        out_found,
    output logic [DIST_WIDTH-1:0]       out_dist
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = 2 * CW + 2;           // one squared difference
    localparam int DW = 2 * CW + 3;           // sum of two squares
    localparam int EW = ID_WIDTH + 2 * CW;    // table entry: {id, y, x}

    logic [COUNT_WIDTH-1:0] count_cfg_reg;
    logic [NW-1:0]          count_sat;
    logic [NW-1:0]          count_reg;
    logic [AW-1:0]          addr_reg;
    logic [CW-1:0]          qx_reg;
    logic [CW-1:0]          qy_reg;
    logic                   idx_ok;
    logic [EW-1:0]          ram_rd_data;
    logic [CW-1:0]          ent_x;
    logic [CW-1:0]          ent_y;
    logic [ID_WIDTH-1:0]    ent_id;
    logic signed [CW:0]     dx;
    logic signed [CW:0]     dy;
    logic [CW:0]            mag_x;
    logic [CW:0]            mag_y;
    logic                   v1_reg;
    logic                   v2_reg;
    logic [SW-1:0]          sq_x_reg;
    logic [SW-1:0]          sq_y_reg;
    logic [ID_WIDTH-1:0]    id2_reg;
    logic [DW-1:0]          dist_sum;
    logic                   take;
    logic                   found_reg;
    logic [DW-1:0]          best_reg;
    logic [ID_WIDTH-1:0]    best_id_reg;
    logic [DW+DIST_WIDTH-1:0] best_wide;
    logic [DIST_WIDTH-1:0]  best_sat;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [ID_WIDTH-1:0]    out_id_reg;
    logic                   out_found_reg;
    logic [DIST_WIDTH-1:0]  out_dist_reg;

    // Entry count register; counts above the table depth search the whole table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            count_cfg_reg <= cfg_wr_data;
        end
    end

    assign count_sat = (32'(count_cfg_reg) > MAX_ENTRIES) ? NW'(MAX_ENTRIES)
                                                          : NW'(count_cfg_reg);

    // Writes to slots beyond the table are dropped
    assign idx_ok = (32'(in_index) < MAX_ENTRIES);

    nps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.wr_entry && idx_ok),
        .wr_addr (AW'(in_index)),
        .wr_data ({in_id, in_y, in_x}),
        .rd_en   (cmd.step),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // Query point, search length and read address
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qx_reg    <= in_x;
            qy_reg    <= in_y;
            count_reg <= count_sat;
            addr_reg  <= '0;
        end else if (cmd.step) begin
            addr_reg  <= addr_reg + AW'(1);
        end
    end

    // Pipeline valid flags: read data, then squared differences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
        end
    end

    // Differences and their squares
    assign ent_x  = ram_rd_data[CW-1:0];
    assign ent_y  = ram_rd_data[2*CW-1:CW];
    assign ent_id = ram_rd_data[EW-1:2*CW];
    assign dx     = $signed({ent_x[CW-1], ent_x}) - $signed({qx_reg[CW-1], qx_reg});
    assign dy     = $signed({ent_y[CW-1], ent_y}) - $signed({qy_reg[CW-1], qy_reg});
    assign mag_x  = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
    assign mag_y  = dy[CW] ? $unsigned(-dy) : $unsigned(dy);

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            sq_x_reg <= SW'(mag_x) * SW'(mag_x);
            sq_y_reg <= SW'(mag_y) * SW'(mag_y);
            id2_reg  <= ent_id;
        end
    end

    // Running minimum; a strict compare keeps the lowest index on a tie
    assign dist_sum = DW'(sq_x_reg) + DW'(sq_y_reg);
    assign take     = v2_reg && (!found_reg || (dist_sum < best_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            best_reg    <= '0;
            best_id_reg <= '0;
        end else if (take) begin
            best_reg    <= dist_sum;
            best_id_reg <= id2_reg;
        end
    end

    // Saturate the distance to the result width
    assign best_wide = (DW + DIST_WIDTH)'(best_reg);
    assign best_sat  = (best_wide > (DW + DIST_WIDTH)'(DIST_MAX)) ? DIST_MAX
                                                                 : best_wide[DIST_WIDTH-1:0];

    // Output register: frees the search while a result waits for its transfer
    assign m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_id_reg    <= best_id_reg;
            out_found_reg <= found_reg;
            out_dist_reg  <= best_sat;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_id    = out_id_reg;
    assign out_found = out_found_reg;
    assign out_dist  = out_dist_reg;

    // Status to the controller
    always_comb begin
        stat          = '0;
        stat.empty    = (count_cfg_reg == '0);
        stat.last     = ((NW'(addr_reg) + NW'(1)) == count_reg);
        stat.busy     = v1_reg || v2_reg;
        stat.out_free = !m_tvalid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ===== src/nearest_point_search_2d.sv =====
// Channel   Direction  Ports                              Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  table write or query point
// m_        out        m_tvalid m_tready m_tdata m_tuser  nearest entry of a query
// cfg_      in         cfg_wr_en cfg_wr_data              entry count register
//
// A write item gives no result. With N the searched count, a query reads one
// entry per cycle for N entries, drains the read, square and compare pipeline
// and then loads its result into the output register, which raises m_tvalid;
// the input reopens once the result is loaded.
// A zero count skips the search and goes straight to loading its result.
// Reset (aresetn, synchronous, active low) clears control state and the count.
// A waiting result does not block the next input transfer; a second query
// stalls at its end until the first result has been transferred.
`default_nettype none

module nearest_point_search_2d
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // entry_index, entry_id, point_x, point_y (from bit 0 up), zero padded
    input  wire logic [((IDX_WIDTH + ID_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // command
    input  wire logic s_tuser,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // closest_id, best_distance_sq (from bit 0 up), zero padded
    output logic [((ID_WIDTH + DIST_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    // found
    output logic      m_tuser,

    input  wire logic                   cfg_wr_en,
    input  wire logic [COUNT_WIDTH-1:0] cfg_wr_data
);

    localparam int CW      = COORD_WIDTH;
    localparam int S_BITS  = IDX_WIDTH + ID_WIDTH + 2 * CW;
    localparam int S_WIDTH = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS  = ID_WIDTH + DIST_WIDTH;
    localparam int M_WIDTH = ((M_BITS + 7) / 8) * 8;
    localparam int X_LO    = IDX_WIDTH + ID_WIDTH;
    localparam int Y_LO    = X_LO + CW;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [ID_WIDTH-1:0]   out_id;
    logic [DIST_WIDTH-1:0] out_dist;
    logic [S_WIDTH-1:0]    s_data;

    assign s_data = s_tdata;

    nps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_command (s_tuser),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nps_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_index    (s_data[IDX_WIDTH-1:0]),
        .in_id       (s_data[X_LO-1:IDX_WIDTH]),
        .in_x        (s_data[Y_LO-1:X_LO]),
        .in_y        (s_data[Y_LO+CW-1:Y_LO]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_id      (out_id),
        .out_found   (m_tuser),
        .out_dist    (out_dist)
    );

    // Result packing with zero padding
    assign m_tdata = M_WIDTH'({out_dist, out_id});

    // A result with nothing found carries zero identifier and distance
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty result carries nonzero payload");

    // A query transfer closes the input until the search is done
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_QUERY)) |=> !s_tready)
        else $error("input still open after a query transfer");

    // A table write never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_WRITE) && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a table write");

    // The compare pipeline is empty whenever the input is open
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.busy)
        else $error("pipeline busy while input is open");

endmodule

`default_nettype wire
